>>> design/pbrm_pkg.sv
// Shared widths, codes and defaults for the paired byte ring manager.
`default_nettype none

package pbrm_pkg;

    localparam int PAIR_COUNT_DEF     = 4;
    localparam int RING_DEPTH_DEF     = 4096;
    localparam int MAX_READ_BURST_DEF = 64;

    localparam int REQ_W        = 3;
    localparam int PAIR_IDX_W   = 2;
    localparam int DATA_W       = 8;
    localparam int READ_COUNT_W = 7;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 13;
    localparam int ALLOC_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 3'd0,
        REQ_READ  = 3'd1,
        REQ_QUERY = 3'd2,
        REQ_RESET = 3'd3,
        REQ_ALLOC = 3'd4,
        REQ_FREE  = 3'd5
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_ALLOC = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NO_FREE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_RD_DATA
    } state_t;

endpackage

`default_nettype wire

>>> design/pbrm_byte_store.sv
// Byte storage for all rings: one write port, one registered read port.
`default_nettype none

module pbrm_byte_store #(
    parameter int PAIR_COUNT = 4,
    parameter int RING_DEPTH = 4096,
    localparam int PAIR_W = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1,
    localparam int RING_W = PAIR_W + 1,
    localparam int PTR_W  = $clog2(RING_DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [RING_W-1:0]           wr_ring,
    input  logic [PTR_W-1:0]            wr_ptr,
    input  logic [pbrm_pkg::DATA_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [RING_W-1:0]           rd_ring,
    input  logic [PTR_W-1:0]            rd_ptr,
    output logic [pbrm_pkg::DATA_W-1:0] rd_data
);
    import pbrm_pkg::*;

    localparam int STORE_DEPTH = 2 * PAIR_COUNT * RING_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic [DATA_W-1:0] store_mem [STORE_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // ring base is a multiply by a constant
    assign wr_addr = ADDR_W'(wr_ring) * ADDR_W'(RING_DEPTH) + ADDR_W'(wr_ptr);
    assign rd_addr = ADDR_W'(rd_ring) * ADDR_W'(RING_DEPTH) + ADDR_W'(rd_ptr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/pbrm_ring_table.sv
// Ring descriptor memory (read pointer, write pointer, fill) with per-ring valid bits.
`default_nettype none

module pbrm_ring_table #(
    parameter int PAIR_COUNT = 4,
    parameter int RING_DEPTH = 4096,
    localparam int PAIR_W = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1,
    localparam int RING_W = PAIR_W + 1,
    localparam int PTR_W  = $clog2(RING_DEPTH),
    localparam int CNT_W  = $clog2(RING_DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [RING_W-1:0] rd_ring,
    output logic [PTR_W-1:0]  rd_rp,
    output logic [PTR_W-1:0]  rd_wp,
    output logic [CNT_W-1:0]  rd_fill,
    input  logic              wr_en,
    input  logic [RING_W-1:0] wr_ring,
    input  logic [PTR_W-1:0]  wr_rp,
    input  logic [PTR_W-1:0]  wr_wp,
    input  logic [CNT_W-1:0]  wr_fill,
    input  logic              clr_en,
    input  logic [PAIR_W-1:0] clr_pair
);
    localparam int RING_COUNT = 2 * PAIR_COUNT;
    localparam int DESC_W     = 2 * PTR_W + CNT_W;

    logic [DESC_W-1:0]     desc_mem [RING_COUNT];
    logic [DESC_W-1:0]     desc_rd_reg;
    logic [RING_COUNT-1:0] valid_reg;
    logic                  hit_reg;

    // an invalid ring reads as empty with both pointers at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (clr_en)
            begin
                valid_reg[{clr_pair, 1'b0}] <= 1'b0;
                valid_reg[{clr_pair, 1'b1}] <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[wr_ring] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_ring];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            desc_mem[wr_ring] <= {wr_rp, wr_wp, wr_fill};
        end
        if (rd_en)
        begin
            desc_rd_reg <= desc_mem[rd_ring];
        end
    end

    assign {rd_rp, rd_wp, rd_fill} = hit_reg ? desc_rd_reg : '0;

endmodule

`default_nettype wire

>>> design/paired_byte_ring_manager.sv
// Top level: request sequencer, pair allocation flags and result register.
// A single result is registered from S_META after the descriptor read and any output stall.
// A read returns its bytes one per cycle while out_stall is low, after the byte store read.
// A new request is taken only in S_IDLE, after the previous one and any read burst are done.
// Each request first reads the descriptor memory; a read then also reads the byte store.
// Reset: no pair allocated, all rings empty; the byte store is not cleared.
`default_nettype none

module paired_byte_ring_manager #(
    parameter int PAIR_COUNT     = pbrm_pkg::PAIR_COUNT_DEF,
    parameter int RING_DEPTH     = pbrm_pkg::RING_DEPTH_DEF,
    parameter int MAX_READ_BURST = pbrm_pkg::MAX_READ_BURST_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pbrm_pkg::REQ_W-1:0]        req_type,
    input  logic [pbrm_pkg::PAIR_IDX_W-1:0]   pair_index,
    input  logic                              side,
    input  logic [pbrm_pkg::DATA_W-1:0]       write_data,
    input  logic [pbrm_pkg::READ_COUNT_W-1:0] read_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pbrm_pkg::STATUS_W-1:0]     status,
    output logic [pbrm_pkg::DATA_W-1:0]       read_data,
    output logic [pbrm_pkg::COUNT_W-1:0]      readable_count,
    output logic [pbrm_pkg::ALLOC_W-1:0]      alloc_index,
    output logic                              last
);
    import pbrm_pkg::*;

    localparam int PAIR_W  = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
    localparam int RING_W  = PAIR_W + 1;
    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int BURST_W = $clog2(MAX_READ_BURST + 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    state_t state_reg, state_next;
    logic [PAIR_COUNT-1:0] alloc_reg, alloc_next;
    logic out_valid_reg, out_valid_next;

    logic [REQ_W-1:0]        req_reg, req_next;
    logic [PAIR_W-1:0]       pair_reg, pair_next;
    logic                    in_range_reg, in_range_next;
    logic [RING_W-1:0]       ring_reg, ring_next;
    logic [DATA_W-1:0]       data_reg, data_next;
    logic [READ_COUNT_W-1:0] want_reg, want_next;
    logic [PTR_W-1:0]        rp_reg, rp_next;
    logic [PTR_W-1:0]        wp_reg, wp_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [BURST_W-1:0]      rem_reg, rem_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   rdata_reg, rdata_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ALLOC_W-1:0]  aidx_reg, aidx_next;
    logic                last_reg, last_next;

    logic [RING_W-1:0] ring_in;
    logic              dir_in;
    logic              live;
    logic              out_ready;
    logic              any_free;
    logic [PAIR_W-1:0] free_idx;
    logic              full;
    logic              burst_last;
    logic [PTR_W-1:0]  rp_step;

    logic              tbl_rd_en;
    logic [PTR_W-1:0]  desc_rp;
    logic [PTR_W-1:0]  desc_wp;
    logic [CNT_W-1:0]  desc_fill;
    logic              tbl_wr_en;
    logic [PTR_W-1:0]  tbl_wr_rp;
    logic [PTR_W-1:0]  tbl_wr_wp;
    logic [CNT_W-1:0]  tbl_wr_fill;
    logic              clr_en;
    logic [PAIR_W-1:0] clr_pair;

    logic              st_wr_en;
    logic              st_rd_en;
    logic [PTR_W-1:0]  st_rd_ptr;
    logic [DATA_W-1:0] st_rd_data;

    // writers fill the far ring, readers drain the near one
    assign dir_in  = (req_type == REQ_WRITE) ? ~side : side;
    assign ring_in = {PAIR_W'(pair_index), dir_in};

    assign live       = in_range_reg && alloc_reg[pair_reg];
    assign out_ready  = !out_valid_reg || !out_stall;
    assign full       = (desc_fill == CNT_W'(RING_DEPTH));
    assign burst_last = (rem_reg == BURST_W'(1)) || (fill_reg == CNT_W'(1));
    assign rp_step    = ptr_inc(rp_reg);

    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = PAIR_COUNT - 1; i >= 0; i--)
        begin
            if (!alloc_reg[i])
            begin
                any_free = 1'b1;
                free_idx = PAIR_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        alloc_next     = alloc_reg;
        out_valid_next = out_valid_reg && out_stall;
        req_next       = req_reg;
        pair_next      = pair_reg;
        in_range_next  = in_range_reg;
        ring_next      = ring_reg;
        data_next      = data_reg;
        want_next      = want_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        rem_next       = rem_reg;
        status_next    = status_reg;
        rdata_next     = rdata_reg;
        count_next     = count_reg;
        aidx_next      = aidx_reg;
        last_next      = last_reg;
        tbl_rd_en      = 1'b0;
        tbl_wr_en      = 1'b0;
        tbl_wr_rp      = '0;
        tbl_wr_wp      = '0;
        tbl_wr_fill    = '0;
        clr_en         = 1'b0;
        clr_pair       = pair_reg;
        st_wr_en       = 1'b0;
        st_rd_en       = 1'b0;
        st_rd_ptr      = desc_rp;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = req_type;
                    pair_next     = PAIR_W'(pair_index);
                    in_range_next = int'(pair_index) < PAIR_COUNT;
                    ring_next     = ring_in;
                    data_next     = write_data;
                    want_next     = read_count;
                    tbl_rd_en     = 1'b1;
                    state_next    = S_META;
                end
            end

            S_META:
            begin
                if (req_reg == REQ_READ && live && desc_fill != '0)
                begin
                    // first byte fetch; results follow from S_RD_DATA
                    st_rd_en  = 1'b1;
                    st_rd_ptr = desc_rp;
                    rp_next   = desc_rp;
                    wp_next   = desc_wp;
                    fill_next = desc_fill;
                    if (want_reg == '0)
                    begin
                        rem_next = BURST_W'(1);
                    end
                    else if (int'(want_reg) > MAX_READ_BURST)
                    begin
                        rem_next = BURST_W'(MAX_READ_BURST);
                    end
                    else
                    begin
                        rem_next = BURST_W'(want_reg);
                    end
                    state_next = S_RD_DATA;
                end
                else if (out_ready)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    rdata_next     = '0;
                    count_next     = '0;
                    aidx_next      = '0;
                    last_next      = 1'b1;
                    unique case (req_reg)
                        REQ_WRITE:
                        begin
                            if (!live)
                            begin
                                status_next = ST_NOT_ALLOC;
                            end
                            else
                            begin
                                // full ring drops its oldest byte
                                st_wr_en    = 1'b1;
                                tbl_wr_en   = 1'b1;
                                tbl_wr_wp   = ptr_inc(desc_wp);
                                tbl_wr_rp   = full ? ptr_inc(desc_rp) : desc_rp;
                                tbl_wr_fill = full ? desc_fill : desc_fill + CNT_W'(1);
                            end
                        end
                        REQ_READ:
                        begin
                            status_next = live ? ST_EMPTY : ST_NOT_ALLOC;
                        end
                        REQ_QUERY:
                        begin
                            count_next = live ? COUNT_W'(desc_fill) : '0;
                        end
                        REQ_RESET:
                        begin
                            if (!live)
                            begin
                                status_next = ST_NOT_ALLOC;
                            end
                            else
                            begin
                                clr_en = 1'b1;
                            end
                        end
                        REQ_ALLOC:
                        begin
                            if (any_free)
                            begin
                                alloc_next[free_idx] = 1'b1;
                                clr_en               = 1'b1;
                                clr_pair             = free_idx;
                                aidx_next            = ALLOC_W'(free_idx);
                            end
                            else
                            begin
                                status_next = ST_NO_FREE;
                            end
                        end
                        REQ_FREE:
                        begin
                            if (!in_range_reg)
                            begin
                                status_next = ST_NOT_ALLOC;
                            end
                            else
                            begin
                                alloc_next[pair_reg] = 1'b0;
                                clr_en               = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOT_ALLOC;
                        end
                    endcase
                end
            end

            S_RD_DATA:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    rdata_next     = st_rd_data;
                    count_next     = '0;
                    aidx_next      = '0;
                    last_next      = burst_last;
                    rp_next        = rp_step;
                    fill_next      = fill_reg - CNT_W'(1);
                    rem_next       = rem_reg - BURST_W'(1);
                    if (burst_last)
                    begin
                        tbl_wr_en   = 1'b1;
                        tbl_wr_rp   = rp_step;
                        tbl_wr_wp   = wp_reg;
                        tbl_wr_fill = fill_reg - CNT_W'(1);
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        st_rd_en  = 1'b1;
                        st_rd_ptr = rp_step;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alloc_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pair_reg     <= pair_next;
        in_range_reg <= in_range_next;
        ring_reg     <= ring_next;
        data_reg     <= data_next;
        want_reg     <= want_next;
        rp_reg       <= rp_next;
        wp_reg       <= wp_next;
        fill_reg     <= fill_next;
        rem_reg      <= rem_next;
        status_reg   <= status_next;
        rdata_reg    <= rdata_next;
        count_reg    <= count_next;
        aidx_reg     <= aidx_next;
        last_reg     <= last_next;
    end

    pbrm_ring_table #(
        .PAIR_COUNT (PAIR_COUNT),
        .RING_DEPTH (RING_DEPTH)
    ) u_ring_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (tbl_rd_en),
        .rd_ring  (ring_in),
        .rd_rp    (desc_rp),
        .rd_wp    (desc_wp),
        .rd_fill  (desc_fill),
        .wr_en    (tbl_wr_en),
        .wr_ring  (ring_reg),
        .wr_rp    (tbl_wr_rp),
        .wr_wp    (tbl_wr_wp),
        .wr_fill  (tbl_wr_fill),
        .clr_en   (clr_en),
        .clr_pair (clr_pair)
    );

    pbrm_byte_store #(
        .PAIR_COUNT (PAIR_COUNT),
        .RING_DEPTH (RING_DEPTH)
    ) u_byte_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_ring (ring_reg),
        .wr_ptr  (desc_wp),
        .wr_data (data_reg),
        .rd_en   (st_rd_en),
        .rd_ring (ring_reg),
        .rd_ptr  (st_rd_ptr),
        .rd_data (st_rd_data)
    );

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign read_data      = rdata_reg;
    assign readable_count = count_reg;
    assign alloc_index    = aidx_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

>>> design/pbrm_checker.sv
// Port-level checks for the paired byte ring manager, bound to the top level.
`default_nettype none

module pbrm_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [pbrm_pkg::STATUS_W-1:0] status,
    input wire logic [pbrm_pkg::DATA_W-1:0]   read_data,
    input wire logic [pbrm_pkg::COUNT_W-1:0]  readable_count,
    input wire logic [pbrm_pkg::ALLOC_W-1:0]  alloc_index,
    input wire logic                          last
);
    import pbrm_pkg::*;

    // a burst still in flight keeps new requests out
    a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("request accepted during a read burst");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && read_data == '0 && readable_count == '0)
        else $error("error result carries payload or is not final");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken right after the first");

    a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alloc_index != '0 |-> status == ST_OK && last && !out_stall || status == ST_OK)
        else $error("pair index reported on a failed request");

endmodule

bind paired_byte_ring_manager pbrm_checker u_pbrm_checker (.*);

`default_nettype wire

>>> tb/paired_byte_ring_manager_test.sv
// Self-checking testbench for paired_byte_ring_manager: predicted results checked against the DUT.
`timescale 1ns / 1ps

module paired_byte_ring_manager_test;

    import pbrm_pkg::*;

    localparam int PAIRS       = PAIR_COUNT_DEF;
    localparam int DEPTH       = RING_DEPTH_DEF;
    localparam int BURST_MAX   = MAX_READ_BURST_DEF;
    localparam int RINGS       = PAIRS * 2;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    // request codes with no defined meaning
    localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

    typedef struct {
        status_t              status;
        logic [DATA_W-1:0]    read_data;
        logic [COUNT_W-1:0]   readable_count;
        logic [ALLOC_W-1:0]   alloc_index;
        logic                 last;
    } ring_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [REQ_W-1:0]        req_type;
    logic [PAIR_IDX_W-1:0]   pair_index;
    logic                    side;
    logic [DATA_W-1:0]       write_data;
    logic [READ_COUNT_W-1:0] read_count;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [DATA_W-1:0]       read_data;
    logic [COUNT_W-1:0]      readable_count;
    logic [ALLOC_W-1:0]      alloc_index;
    logic                    last;

    // predictor state
    logic              pair_live [PAIRS];
    logic [DATA_W-1:0] ring_bytes [RINGS][DEPTH];
    int                ring_head [RINGS];
    int                ring_tail [RINGS];
    int                ring_fill [RINGS];

    ring_result_t pending_results[$];

    int error_count     = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    // long output hold-off, started by toggling hold_trigger
    logic hold_trigger = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;

    paired_byte_ring_manager DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .pair_index     (pair_index),
        .side           (side),
        .write_data     (write_data),
        .read_count     (read_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_data      (read_data),
        .readable_count (readable_count),
        .alloc_index    (alloc_index),
        .last           (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned exp_v);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH %s: got %0d expected %0d (result %0d, cycle %0d)",
                     what, got_v, exp_v, results_checked, cycle_count);
    endtask

    function automatic void push_result(input status_t st, input logic [DATA_W-1:0] d,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [ALLOC_W-1:0] a, input logic l);
        ring_result_t r;
        r.status         = st;
        r.read_data      = d;
        r.readable_count = cnt;
        r.alloc_index    = a;
        r.last           = l;
        pending_results.push_back(r);
    endfunction

    function automatic void clear_rings(input int p);
        for (int k = p * 2; k < p * 2 + 2; k++)
        begin
            ring_head[k] = 0;
            ring_tail[k] = 0;
            ring_fill[k] = 0;
        end
    endfunction

    function automatic void predict_request(input logic [REQ_W-1:0] req,
                                            input logic [PAIR_IDX_W-1:0] pair,
                                            input logic sd, input logic [DATA_W-1:0] data,
                                            input logic [READ_COUNT_W-1:0] count);
        int  p;
        int  ring;
        int  want;
        int  n;
        bit  in_range;
        bit  live;
        bit  granted;
        p        = int'(pair);
        in_range = p < PAIRS;
        live     = in_range && pair_live[p];
        case (req)
            REQ_WRITE:
            begin
                if (!live)
                    push_result(ST_NOT_ALLOC, '0, '0, '0, 1'b1);
                else
                begin
                    // side 1 fills ring 0, side 0 fills ring 1
                    ring = p * 2 + (sd ? 0 : 1);
                    if (ring_fill[ring] >= DEPTH)
                    begin
                        ring_head[ring] = (ring_head[ring] + 1) % DEPTH;
                        ring_fill[ring]--;
                    end
                    ring_bytes[ring][ring_tail[ring]] = data;
                    ring_tail[ring] = (ring_tail[ring] + 1) % DEPTH;
                    ring_fill[ring]++;
                    push_result(ST_OK, '0, '0, '0, 1'b1);
                end
            end
            REQ_READ:
            begin
                ring = p * 2 + (sd ? 1 : 0);
                if (!live)
                    push_result(ST_NOT_ALLOC, '0, '0, '0, 1'b1);
                else if (ring_fill[ring] == 0)
                    push_result(ST_EMPTY, '0, '0, '0, 1'b1);
                else
                begin
                    want = int'(count);
                    if (want == 0)
                        want = 1;
                    if (want > BURST_MAX)
                        want = BURST_MAX;
                    n = (ring_fill[ring] < want) ? ring_fill[ring] : want;
                    for (int k = 0; k < n; k++)
                    begin
                        push_result(ST_OK, ring_bytes[ring][ring_head[ring]], '0, '0,
                                    k == n - 1);
                        ring_head[ring] = (ring_head[ring] + 1) % DEPTH;
                        ring_fill[ring]--;
                    end
                end
            end
            REQ_QUERY:
            begin
                if (live)
                    push_result(ST_OK, '0, COUNT_W'(ring_fill[p * 2 + (sd ? 1 : 0)]), '0,
                                1'b1);
                else
                    push_result(ST_OK, '0, '0, '0, 1'b1);
            end
            REQ_RESET:
            begin
                if (!live)
                    push_result(ST_NOT_ALLOC, '0, '0, '0, 1'b1);
                else
                begin
                    clear_rings(p);
                    push_result(ST_OK, '0, '0, '0, 1'b1);
                end
            end
            REQ_ALLOC:
            begin
                granted = 1'b0;
                for (int k = 0; k < PAIRS; k++)
                begin
                    if (!granted && !pair_live[k])
                    begin
                        granted      = 1'b1;
                        pair_live[k] = 1'b1;
                        clear_rings(k);
                        push_result(ST_OK, '0, '0, ALLOC_W'(k), 1'b1);
                    end
                end
                if (!granted)
                    push_result(ST_NO_FREE, '0, '0, '0, 1'b1);
            end
            REQ_FREE:
            begin
                if (!in_range)
                    push_result(ST_NOT_ALLOC, '0, '0, '0, 1'b1);
                else
                begin
                    pair_live[p] = 1'b0;
                    clear_rings(p);
                    push_result(ST_OK, '0, '0, '0, 1'b1);
                end
            end
            default:
                push_result(ST_NOT_ALLOC, '0, '0, '0, 1'b1);
        endcase
    endfunction

    // Called and returns at a rising edge; valid stays high for back-to-back requests.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [PAIR_IDX_W-1:0] pair,
                                input logic sd, input logic [DATA_W-1:0] data,
                                input logic [READ_COUNT_W-1:0] count);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        pair_index <= pair;
        side       <= sd;
        write_data <= data;
        read_count <= count;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(req, pair, sd, data, count);
        requests_sent++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    function automatic logic [DATA_W-1:0] rand_byte();
        return DATA_W'($urandom_range(255));
    endfunction

    function automatic logic [READ_COUNT_W-1:0] rand_count();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return READ_COUNT_W'($urandom_range(127, 60));
        return READ_COUNT_W'($urandom_range(16, 1));
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int k = 0; k < PAIRS; k++)
            if (pair_live[k])
                n++;
        return n;
    endfunction

    // mostly an allocated pair, sometimes any pair
    function automatic logic [PAIR_IDX_W-1:0] pick_pair();
        int live_idx[$];
        for (int k = 0; k < PAIRS; k++)
            if (pair_live[k])
                live_idx.push_back(k);
        if (live_idx.size() == 0 || $urandom_range(7) == 0)
            return PAIR_IDX_W'($urandom_range(PAIRS - 1));
        return PAIR_IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
    endfunction

    task automatic test_unallocated();
        send_request(REQ_QUERY, 2'd0, 1'b0, 8'h00, 7'd0);
        send_request(REQ_QUERY, 2'd3, 1'b1, 8'hFF, 7'd127);
        send_request(REQ_WRITE, 2'd1, 1'b1, 8'hA5, 7'd1);
        send_request(REQ_READ,  2'd2, 1'b0, 8'h00, 7'd64);
        send_request(REQ_RESET, 2'd3, 1'b0, 8'h00, 7'd1);
        send_request(REQ_FREE,  2'd1, 1'b1, 8'h00, 7'd1);
        send_request(REQ_RSVD_A, 2'd0, 1'b0, 8'h00, 7'd1);
        send_request(REQ_RSVD_B, 2'd3, 1'b1, 8'hFF, 7'd127);
    endtask

    task automatic test_alloc_free();
        repeat (PAIRS + 1)
            send_request(REQ_ALLOC, 2'($urandom_range(3)), 1'b0, 8'h00, 7'd1);
        send_request(REQ_FREE,  2'd2, 1'b0, 8'h00, 7'd1);
        send_request(REQ_ALLOC, 2'd0, 1'b1, 8'h00, 7'd1);
        send_request(REQ_FREE,  2'd3, 1'b0, 8'h00, 7'd1);
        send_request(REQ_FREE,  2'd3, 1'b1, 8'h00, 7'd1);
        send_request(REQ_WRITE, 2'd3, 1'b1, 8'h11, 7'd1);
    endtask

    task automatic test_byte_paths();
        send_request(REQ_WRITE, 2'd0, 1'b1, 8'h00, 7'd0);
        send_request(REQ_WRITE, 2'd0, 1'b1, 8'hFF, 7'd0);
        send_request(REQ_QUERY, 2'd0, 1'b0, 8'h00, 7'd0);
        send_request(REQ_QUERY, 2'd0, 1'b1, 8'h00, 7'd0);
        // zero count is raised to one, oversize count clipped to the burst limit
        send_request(REQ_READ,  2'd0, 1'b0, 8'h00, 7'd0);
        send_request(REQ_READ,  2'd0, 1'b0, 8'h00, 7'd127);
        send_request(REQ_READ,  2'd0, 1'b0, 8'h00, 7'd5);
        send_request(REQ_READ,  2'd0, 1'b1, 8'h00, 7'd5);
        for (int k = 0; k < 6; k++)
            send_request(REQ_WRITE, 2'd1, 1'b0, 8'(k * 37 + 1), 7'd0);
        send_request(REQ_READ,  2'd1, 1'b1, 8'h00, 7'd64);
        send_request(REQ_WRITE, 2'd1, 1'b1, 8'h5A, 7'd0);
        send_request(REQ_RESET, 2'd1, 1'b0, 8'h00, 7'd0);
        send_request(REQ_QUERY, 2'd1, 1'b0, 8'h00, 7'd0);
    endtask

    // write 24 bytes to one ring, drain it with an oversize read, then read it again while empty
    task automatic test_ring_fill();
        for (int k = 0; k < 24; k++)
            send_request(REQ_WRITE, 2'd2, 1'b1, 8'(k) ^ 8'h5A, 7'(k));
        send_request(REQ_QUERY, 2'd2, 1'b0, 8'h00, 7'd0);
        send_request(REQ_READ,  2'd2, 1'b0, 8'h00, 7'd127);
        send_request(REQ_READ,  2'd2, 1'b0, 8'h00, 7'd65);
        send_request(REQ_QUERY, 2'd2, 1'b0, 8'h00, 7'd0);
        send_request(REQ_RESET, 2'd2, 1'b1, 8'h00, 7'd0);
        send_request(REQ_QUERY, 2'd2, 1'b0, 8'h00, 7'd0);
        send_request(REQ_READ,  2'd2, 1'b1, 8'h00, 7'd3);
    endtask

    task automatic run_random_traffic(input int n);
        int                    sent;
        int                    pick;
        int                    burst;
        logic [PAIR_IDX_W-1:0] pair;
        logic                  sd;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            pair = pick_pair();
            sd   = 1'($urandom_range(1));
            if (live_count() == 0 || pick < 7)
                send_request(REQ_ALLOC, pair, sd, rand_byte(), rand_count());
            else if (pick < 11)
                send_request(REQ_FREE, pair, sd, rand_byte(), rand_count());
            else if (pick < 15)
                send_request(REQ_RESET, pair, sd, rand_byte(), rand_count());
            else if (pick < 18)
                send_request($urandom_range(1) ? REQ_RSVD_A : REQ_RSVD_B, pair, sd,
                             rand_byte(), rand_count());
            else if (pick < 30)
                send_request(REQ_QUERY, pair, sd, rand_byte(), rand_count());
            else if (pick < 50)
                send_request(REQ_READ, pair, sd, rand_byte(), rand_count());
            if (pick < 50)
                sent++;
            else
            begin
                burst = $urandom_range(8, 1);
                for (int k = 0; k < burst; k++)
                    send_request(REQ_WRITE, pair, sd, rand_byte(), rand_count());
                sent += burst;
            end
        end
    endtask

    // receiver holds off while requests keep coming, so the block backs up
    task automatic test_output_holdoff();
        if (live_count() == 0)
            send_request(REQ_ALLOC, 2'd0, 1'b0, 8'h00, 7'd1);
        hold_trigger <= ~hold_trigger;
        for (int k = 0; k < 24; k++)
            send_request(REQ_WRITE, pick_pair(), 1'($urandom_range(1)), rand_byte(), 7'd0);
        for (int k = 0; k < 8; k++)
            send_request(REQ_READ, pick_pair(), 1'($urandom_range(1)), 8'h00, rand_count());
        wait_for_drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_output
        ring_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, status", status, 0);
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                    report_mismatch("status", status, exp_r.status);
                if (read_data !== exp_r.read_data)
                    report_mismatch("read_data", read_data, exp_r.read_data);
                if (readable_count !== exp_r.readable_count)
                    report_mismatch("readable_count", readable_count, exp_r.readable_count);
                if (alloc_index !== exp_r.alloc_index)
                    report_mismatch("alloc_index", alloc_index, exp_r.alloc_index);
                if (last !== exp_r.last)
                    report_mismatch("last", last, exp_r.last);
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = '0;
        pair_index = '0;
        side       = 1'b0;
        write_data = '0;
        read_count = '0;
        for (int k = 0; k < PAIRS; k++)
        begin
            pair_live[k] = 1'b0;
            clear_rings(k);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(0, 0);
        test_unallocated();
        test_alloc_free();
        test_byte_paths();
        test_ring_fill();
        wait_for_drain();

        set_idle(0, 0);
        run_random_traffic(45);
        set_idle(72, 0);
        run_random_traffic(45);
        wait_for_drain();
        set_idle(0, 72);
        run_random_traffic(45);
        set_idle(18, 18);
        run_random_traffic(45);
        test_output_holdoff();

        wait_for_drain();
        repeat (20) @(posedge clk);
        $display("Covered: allocation limits, unallocated pairs, count clipping, ring fill");
        $display("and drain, random traffic under four idle patterns and a long output hold-off");
        $display("%0d requests, %0d results", requests_sent, results_checked);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
